// ----- design/rotation_matrix_to_quaternion_macros.svh -----
// Assertion macros used by the checker file
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RMTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmtq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define RMTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmtq: next-cycle check failed");

`endif

// ----- design/rmtq_pkg.sv -----
package rmtq_pkg;

	localparam int DATA_W        = 16;
	localparam int NUM_W         = 17;  // magnitude of an off-diagonal sum or difference
	localparam int QB            = 16;  // quotient bits produced by the divider chain
	localparam int FRAC_BITS_DEF = 14;

	// branch codes
	localparam logic [1:0] SEL_TRACE = 2'd0;
	localparam logic [1:0] SEL_M00   = 2'd1;
	localparam logic [1:0] SEL_M11   = 2'd2;
	localparam logic [1:0] SEL_M22   = 2'd3;

	localparam logic [DATA_W-1:0] POS_MAX = 16'h7fff;
	localparam logic [DATA_W-1:0] NEG_MIN = 16'h8000;

	// data that rides along the root chain
	typedef struct packed {
		logic [1:0]            sel;
		logic [2:0]            sgn;
		logic [2:0][NUM_W-1:0] mag;
	} sq_side_t;

	// data that rides along the divider chain
	typedef struct packed {
		logic [1:0]        sel;
		logic [2:0]        sgn;
		logic [2:0]        ovf;
		logic [DATA_W-1:0] big;
		logic              degen;
	} div_side_t;

endpackage

// ----- design/rmtq_sqrt_cell.sv -----
module rmtq_sqrt_cell #(
	parameter int HW = 16,
	parameter int XW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [HW+2:0]       in_rem,
	input  logic [HW-1:0]       in_root,
	input  logic [XW-1:0]       in_x,
	input  rmtq_pkg::sq_side_t  in_side,
	output logic                out_valid,
	output logic [HW+2:0]       out_rem,
	output logic [HW-1:0]       out_root,
	output logic [XW-1:0]       out_x,
	output rmtq_pkg::sq_side_t  out_side
);
	import rmtq_pkg::*;

	logic [HW+2:0] r2;
	logic [HW+2:0] trial;
	logic          ge;

	// one root bit: bring down two radicand bits, try 4q+1
	always_comb begin
		r2    = {in_rem[HW:0], in_x[XW-1 -: 2]};
		trial = {1'b0, in_root, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= ge ? (r2 - trial) : r2;
			out_root <= {in_root[HW-2:0], ge};
			out_x    <= {in_x[XW-3:0], 2'b00};
			out_side <= in_side;
		end
	end

endmodule

// ----- design/rmtq_div_cell.sv -----
module rmtq_div_cell #(
	parameter int DW = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][DW-1:0]            in_rem,
	input  logic [DW-1:0]                 in_dsh,
	input  logic [2:0][rmtq_pkg::QB-1:0]  in_q,
	input  rmtq_pkg::div_side_t           in_side,
	output logic                          out_valid,
	output logic [2:0][DW-1:0]            out_rem,
	output logic [DW-1:0]                 out_dsh,
	output logic [2:0][rmtq_pkg::QB-1:0]  out_q,
	output rmtq_pkg::div_side_t           out_side
);
	import rmtq_pkg::*;

	logic [2:0] ge;

	// one quotient bit per lane against the shifted divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ge[i] = (in_rem[i] >= in_dsh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_rem[i] <= ge[i] ? (in_rem[i] - in_dsh) : in_rem[i];
				out_q[i]   <= {in_q[i][QB-2:0], ge[i]};
			end
			out_dsh  <= in_dsh >> 1;
			out_side <= in_side;
		end
	end

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion, four-branch trace method, fixed point.
// Input channel s_*: one beat carries the nine matrix elements m00..m22,
// signed with FRAC_BITS fraction bits. Output channel m_*: one beat carries
// quat_w..quat_z in tdata and the branch code and degenerate flag in tuser.
// Throughput: one beat per cycle while the receiver takes beats. In order, a
// beat passes an input stage, the root chain (one cell per root bit, HW cells,
// HW being half the padded radicand width, 16 at 14 fraction bits), a stage
// that forms the dividends, the divider chain (one cell per quotient bit, 16
// cells) and the output register.
// The whole pipeline advances together; when the receiver stalls with a beat
// waiting, every stage holds and s_tready drops in the same cycle.
// Reset clears all valid bits; no beat is shown until a new one has passed
// through the full pipeline.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmtq_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic [2:0]   m_tuser   // case_taken[1:0], degenerate
);
	import rmtq_pkg::*;

	localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int XR = RW + FRAC_BITS;
	localparam int XW = XR + (XR % 2);
	localparam int HW = XW / 2;
	localparam int NW = NUM_W + FRAC_BITS + 1;
	localparam int DV = HW + QB + 1;
	localparam int DW = (NW > DV) ? NW : DV;
	localparam logic signed [RW:0] ONE = (RW+1)'(64'd1 << FRAC_BITS);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- input stage: branch, radicand, numerators
	logic signed [DATA_W-1:0] m [9];
	logic signed [RW:0]       a00, a11, a22, trace, rad_s;
	logic [1:0]               sel;
	logic signed [NUM_W:0]    nv [6];
	logic signed [NUM_W:0]    ln [3];
	sq_side_t                 side_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i*DATA_W +: DATA_W];
		end
		a00   = (RW+1)'(m[0]);
		a11   = (RW+1)'(m[4]);
		a22   = (RW+1)'(m[8]);
		trace = a00 + a11 + a22;
		if (trace > 0) begin
			sel   = SEL_TRACE;
			rad_s = trace + ONE;
		end else if (a00 > a11 && a00 > a22) begin
			sel   = SEL_M00;
			rad_s = ONE + a00 - a11 - a22;
		end else if (a11 > a22) begin
			sel   = SEL_M11;
			rad_s = ONE + a11 - a00 - a22;
		end else begin
			sel   = SEL_M22;
			rad_s = ONE + a22 - a00 - a11;
		end
		// off-diagonal pairs
		nv[0] = (NUM_W+1)'(m[7]) - (NUM_W+1)'(m[5]);  // m21 - m12
		nv[1] = (NUM_W+1)'(m[2]) - (NUM_W+1)'(m[6]);  // m02 - m20
		nv[2] = (NUM_W+1)'(m[3]) - (NUM_W+1)'(m[1]);  // m10 - m01
		nv[3] = (NUM_W+1)'(m[1]) + (NUM_W+1)'(m[3]);  // m01 + m10
		nv[4] = (NUM_W+1)'(m[2]) + (NUM_W+1)'(m[6]);  // m02 + m20
		nv[5] = (NUM_W+1)'(m[5]) + (NUM_W+1)'(m[7]);  // m12 + m21
		// lanes hold the three non-big components in index order
		case (sel)
			SEL_TRACE: begin
				ln[0] = nv[0]; ln[1] = nv[1]; ln[2] = nv[2];
			end
			SEL_M00: begin
				ln[0] = nv[0]; ln[1] = nv[3]; ln[2] = nv[4];
			end
			SEL_M11: begin
				ln[0] = nv[1]; ln[1] = nv[3]; ln[2] = nv[5];
			end
			default: begin
				ln[0] = nv[2]; ln[1] = nv[4]; ln[2] = nv[5];
			end
		endcase
		side_c.sel = sel;
		for (int i = 0; i < 3; i++) begin
			side_c.sgn[i] = ln[i][NUM_W];
			side_c.mag[i] = ln[i][NUM_W] ? NUM_W'(-ln[i]) : ln[i][NUM_W-1:0];
		end
	end

	logic          v_s1;
	logic [XW-1:0] x_s1;
	sq_side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// clamp negative radicand, scale by one
			x_s1    <= rad_s[RW] ? '0 : XW'({rad_s[RW-1:0], {FRAC_BITS{1'b0}}});
			side_s1 <= side_c;
		end
	end

	// ---------------- root chain, one bit per cell
	logic           sv   [HW+1];
	logic [HW+2:0]  srem [HW+1];
	logic [HW-1:0]  sroot[HW+1];
	logic [XW-1:0]  sx   [HW+1];
	sq_side_t       sside[HW+1];

	assign sv[0]    = v_s1;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sx[0]    = x_s1;
	assign sside[0] = side_s1;

	for (genvar k = 0; k < HW; k++) begin : g_sqrt
		rmtq_sqrt_cell #(.HW(HW), .XW(XW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sv[k]),
			.in_rem   (srem[k]),
			.in_root  (sroot[k]),
			.in_x     (sx[k]),
			.in_side  (sside[k]),
			.out_valid(sv[k+1]),
			.out_rem  (srem[k+1]),
			.out_root (sroot[k+1]),
			.out_x    (sx[k+1]),
			.out_side (sside[k+1])
		);
	end

	// ---------------- dividend stage: n*2^F + h over 2h, overflow check
	logic [HW-1:0]     h;
	logic [DW-1:0]     dsor16;
	logic [2:0][DW-1:0] nd;
	logic [HW:0]       big_w;
	div_side_t         dside_c;

	always_comb begin
		h      = sroot[HW];
		dsor16 = DW'(h) << (QB + 1);
		big_w  = ({1'b0, h} + 1'b1) >> 1;
		dside_c.sel   = sside[HW].sel;
		dside_c.sgn   = sside[HW].sgn;
		dside_c.degen = (h == '0);
		dside_c.big   = (big_w > (HW+1)'(POS_MAX)) ? POS_MAX : DATA_W'(big_w);
		for (int i = 0; i < 3; i++) begin
			nd[i] = (DW'(sside[HW].mag[i]) << FRAC_BITS) + DW'(h);
			dside_c.ovf[i] = (nd[i] >= dsor16);
		end
	end

	logic               v_s2;
	logic [2:0][DW-1:0] nd_s2;
	logic [DW-1:0]      dsh_s2;
	div_side_t          dside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sv[HW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nd_s2[i] <= dside_c.ovf[i] ? '0 : nd[i];
			end
			dsh_s2   <= DW'(h) << QB;
			dside_s2 <= dside_c;
		end
	end

	// ---------------- divider chain, one quotient bit per cell
	logic               dv   [QB+1];
	logic [2:0][DW-1:0] drem [QB+1];
	logic [DW-1:0]      ddsh [QB+1];
	logic [2:0][QB-1:0] dq   [QB+1];
	div_side_t          dside[QB+1];

	assign dv[0]    = v_s2;
	assign drem[0]  = nd_s2;
	assign ddsh[0]  = dsh_s2;
	assign dq[0]    = '0;
	assign dside[0] = dside_s2;

	for (genvar k = 0; k < QB; k++) begin : g_div
		rmtq_div_cell #(.DW(DW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv[k]),
			.in_rem   (drem[k]),
			.in_dsh   (ddsh[k]),
			.in_q     (dq[k]),
			.in_side  (dside[k]),
			.out_valid(dv[k+1]),
			.out_rem  (drem[k+1]),
			.out_dsh  (ddsh[k+1]),
			.out_q    (dq[k+1]),
			.out_side (dside[k+1])
		);
	end

	// ---------------- sign, saturation, component placement and degenerate zeroing
	logic [2:0][DATA_W-1:0] lv;
	logic [3:0][DATA_W-1:0] qc;
	div_side_t              fs;

	always_comb begin
		fs = dside[QB];
		for (int i = 0; i < 3; i++) begin
			if (fs.sgn[i]) begin
				lv[i] = (fs.ovf[i] || dq[QB][i] > QB'(NEG_MIN)) ? NEG_MIN
					: DATA_W'(-dq[QB][i]);
			end else begin
				lv[i] = (fs.ovf[i] || dq[QB][i] > QB'(POS_MAX)) ? POS_MAX
					: DATA_W'(dq[QB][i]);
			end
		end
		case (fs.sel)
			SEL_TRACE: qc = {lv[2], lv[1], lv[0], fs.big};
			SEL_M00:   qc = {lv[2], lv[1], fs.big, lv[0]};
			SEL_M11:   qc = {lv[2], fs.big, lv[1], lv[0]};
			default:   qc = {fs.big, lv[2], lv[1], lv[0]};
		endcase
		if (fs.degen) begin
			qc = '0;
		end
	end

	logic                   v_out_q;
	logic [3:0][DATA_W-1:0] quat_q;
	logic [1:0]             sel_q;
	logic                   degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_q  <= qc;
			sel_q   <= fs.sel;
			degen_q <= fs.degen;
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = quat_q;
	assign m_tuser  = {degen_q, sel_q};

endmodule

// ----- design/rmtq_checker.sv -----
module rmtq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [2:0]   m_tuser
);
`include "rotation_matrix_to_quaternion_macros.svh"

	// a stalled output beat holds
	`RMTQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// pipeline freezes on a stall, so input side is closed
	`RMTQ_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready)
	// with the output empty, input is always open
	`RMTQ_ASSERT_NOW(a_open, !m_tvalid, s_tready)
	// degenerate beat carries an all-zero quaternion
	`RMTQ_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[2], m_tdata == 64'd0)

endmodule

bind rotation_matrix_to_quaternion rmtq_checker u_rmtq_checker (.*);

// ----- tb/sv/tb_rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;
	import rmtq_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = 35;
	localparam int N_RANDOM = 1500;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		logic [1:0] sel;
		logic degen;
	} quat_t;

	typedef logic signed [15:0] mat_t [9];

	// one directed row: matrix, and an optional typed-in expectation
	typedef struct {
		mat_t m;
		bit fixed;
		quat_t q;
	} stim_row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [143:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [63:0] m_tdata;
	logic [2:0] m_tuser;

	quat_t quat_queue[$];
	int err_count = 0;
	int beat_count = 0;
	bit src_gaps = 1, sink_gaps = 1;
	bit hold_sink = 0;
	bit src_done = 0;

	rotation_matrix_to_quaternion dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// n * 2^FB / s, round to nearest, ties away from zero
	function automatic longint round_div(longint n, longint unsigned s);
		longint unsigned mag, q;
		longint v;
		mag = (n < 0) ? -n : n;
		q = ((mag << FB) + (s >> 1)) / s;
		v = (q > 64'h7fffffff) ? 64'sh7fffffff : longint'(q);
		return (n < 0) ? -v : v;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic quat_t matrix_to_quat(mat_t m);
		longint a[9];
		longint tr, rad, big, c[4];
		longint unsigned h, s;
		logic [1:0] sel;
		quat_t q;
		foreach (a[i]) a[i] = m[i];
		tr = a[0] + a[4] + a[8];
		if (tr > 0) begin
			sel = SEL_TRACE;
			rad = tr + (64'sd1 << FB);
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			sel = SEL_M00;
			rad = (64'sd1 << FB) + a[0] - a[4] - a[8];
		end else if (a[4] > a[8]) begin
			sel = SEL_M11;
			rad = (64'sd1 << FB) + a[4] - a[0] - a[8];
		end else begin
			sel = SEL_M22;
			rad = (64'sd1 << FB) + a[8] - a[0] - a[4];
		end
		if (rad < 0) rad = 0;
		h = int_sqrt(longint'(rad) << FB);
		s = 2 * h;
		c = '{0, 0, 0, 0};
		if (s != 0) begin
			big = (h + 1) >> 1;
			case (sel)
				SEL_TRACE: c = '{big, round_div(a[7] - a[5], s),
					round_div(a[2] - a[6], s), round_div(a[3] - a[1], s)};
				SEL_M00: c = '{round_div(a[7] - a[5], s), big,
					round_div(a[1] + a[3], s), round_div(a[2] + a[6], s)};
				SEL_M11: c = '{round_div(a[2] - a[6], s),
					round_div(a[1] + a[3], s), big, round_div(a[5] + a[7], s)};
				default: c = '{round_div(a[3] - a[1], s),
					round_div(a[2] + a[6], s), round_div(a[5] + a[7], s), big};
			endcase
		end
		q.w = clip16(c[0]);
		q.x = clip16(c[1]);
		q.y = clip16(c[2]);
		q.z = clip16(c[3]);
		q.sel = sel;
		q.degen = (s == 0);
		return q;
	endfunction

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("mismatch beat %0d %s: expected %0d got %0d", beat_count, what, exp_v, got_v);
		err_count++;
	endtask

	// drive one matrix and wait for its acceptance
	task automatic send_matrix(mat_t m, quat_t q);
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[16*i +: 16] = m[i];
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		quat_queue.push_back(q);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic mat_t rand_matrix();
		mat_t m;
		int mode;
		mode = $urandom_range(0, 9);
		foreach (m[i]) begin
			if (mode < 6) m[i] = $urandom_range(0, 32768) - 16384;   // near rotation range
			else if (mode < 9) m[i] = $urandom();
			else m[i] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
		end
		// sometimes make the diagonal tie or push trace to zero
		if (mode == 5) begin
			m[4] = m[0];
			if ($urandom_range(0, 1)) m[8] = m[0];
		end
		if (mode == 4) m[8] = -(m[0] + m[4]);
		return m;
	endfunction

	// stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		mat_t m;
		quat_t q;
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity: trace branch, w = 1.0
		r.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
		r.fixed = 1;
		r.q = '{w: 16384, x: 0, y: 0, z: 0, sel: SEL_TRACE, degen: 0};
		rows.push_back(r);
		// all zero: trace zero, ties go to m22 branch, radicand 1.0
		r.m = '{default: 0};
		r.fixed = 0;
		rows.push_back(r);
		// 180 deg about x, y, z
		r.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; rows.push_back(r);
		r.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; rows.push_back(r);
		r.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; rows.push_back(r);
		// whole diagonal at the minimum: ties pick the m22 branch, large radicand
		r.m = '{-32768, 100, 200, 300, -32768, 400, 500, 600, -32768};
		rows.push_back(r);
		// extremes of every field
		r.m = '{default: 16'sh7fff}; rows.push_back(r);
		r.m = '{default: 16'sh8000}; rows.push_back(r);
		r.m = '{-1, 16'sh7fff, 16'sh8000, 16'sh8000, -1, 16'sh7fff,
			16'sh7fff, 16'sh8000, -1}; rows.push_back(r);
		r.m = '{100, 16'sh8000, 16'sh7fff, 16'sh7fff, 50, 16'sh8000,
			16'sh8000, 16'sh7fff, 50}; rows.push_back(r);
		// m22 branch with large off-diagonal terms
		r.m = '{-16384, 32767, -32768, -32768, -16384, 32767, 32767, 32767, 0};
		rows.push_back(r);
		// diagonal ties
		r.m = '{0, 1, 2, 3, 0, 5, 6, 7, -5}; rows.push_back(r);
		r.m = '{-5, 1, 2, 3, -2, 5, 6, 7, -2}; rows.push_back(r);
		// trace exactly one lsb positive
		r.m = '{1, 9, -9, 9, 0, -9, 9, 9, 0}; rows.push_back(r);

		foreach (rows[i]) begin
			q = rows[i].fixed ? rows[i].q : matrix_to_quat(rows[i].m);
			send_matrix(rows[i].m, q);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 200) begin
				src_gaps = 0;
				sink_gaps = 0;
			end
			m = rand_matrix();
			send_matrix(m, matrix_to_quat(m));
		end
		s_tvalid <= 0;
		src_done = 1;
	end

	// receiver: random stall bursts, plus one long hold-off
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) m_tready <= 0;
			else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(0, 13)) @(posedge clk);
			end
			else m_tready <= 1;
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_sink = 1;
		repeat (150) @(posedge clk);
		hold_sink = 0;
	end

	// result check
	always @(posedge clk) begin
		quat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (quat_queue.size() == 0) begin
				$display("unexpected beat %0d", beat_count);
				err_count++;
			end else begin
				e = quat_queue.pop_front();
				if (m_tdata[15:0] !== e.w) report_mismatch("quat_w", e.w, $signed(m_tdata[15:0]));
				if (m_tdata[31:16] !== e.x) report_mismatch("quat_x", e.x, $signed(m_tdata[31:16]));
				if (m_tdata[47:32] !== e.y) report_mismatch("quat_y", e.y, $signed(m_tdata[47:32]));
				if (m_tdata[63:48] !== e.z) report_mismatch("quat_z", e.z, $signed(m_tdata[63:48]));
				if (m_tuser[1:0] !== e.sel) report_mismatch("case_taken", e.sel, m_tuser[1:0]);
				if (m_tuser[2] !== e.degen) report_mismatch("degenerate", e.degen, m_tuser[2]);
			end
			beat_count++;
		end
	end

	// end of run
	initial begin
		wait (src_done);
		while (quat_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (err_count == 0 && quat_queue.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#200000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/rmtq_pkg.sv
design/rmtq_sqrt_cell.sv
design/rmtq_div_cell.sv
design/rotation_matrix_to_quaternion.sv
design/rmtq_checker.sv
tb/sv/tb_rotation_matrix_to_quaternion.sv
